// ----- rtl/core/rcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsd_pkg: shared types and constants for the servo frame decoder
// Frame layout constants, config register indexes, capture-to-emit handoff.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsd_pkg;

  localparam int PAYLOAD_BYTES = 22;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int CH_W          = 11;
  localparam int CH_COUNT      = 16;
  localparam int CH_IDX_W      = 4;
  localparam int OPT_W         = 4;

  localparam logic [4:0] POS_HEADER = 5'd0;
  localparam logic [4:0] POS_LAST_PAYLOAD = 5'd22;
  localparam logic [4:0] POS_OPTION = 5'd23;
  localparam logic [4:0] POS_END    = 5'd24;

  localparam logic [CH_IDX_W-1:0] CH_LAST = 4'd15;

  // Config register indexes
  localparam logic [0:0] CFG_HEADER = 1'b0;
  localparam logic [0:0] CFG_END    = 1'b1;

  // Reset values of config registers
  localparam logic [7:0] HEADER_RST = 8'h0F;
  localparam logic [7:0] END_RST    = 8'h00;

  // One completed frame handed from capture to the emitter
  typedef struct packed {
    logic                 valid;
    logic                 good;
    logic [OPT_W-1:0]     opt;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

endpackage

`default_nettype wire

// ----- rtl/core/rcsd_capture.sv -----
// ----------------------------------------------------------------------------
// rcsd_capture: byte counter and frame store
// Tracks frame position, stores payload/option bytes, checks header and end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsd_capture (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_addr,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                byte_vld,
  input  wire logic [7:0]          data_byte,
  input  wire logic                first,
  output logic                     at_end,
  output rcsd_pkg::frame_t         frame
);
  import rcsd_pkg::*;

  logic [7:0]       header_value_r;
  logic [7:0]       end_value_r;
  logic [4:0]       byte_pos_r, byte_pos_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [OPT_W-1:0] opt_r, opt_nxt;
  logic [7:0]       store_r [PAYLOAD_BYTES];
  logic [4:0]       pos;
  logic [4:0]       store_idx;
  logic             store_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_value_r <= HEADER_RST;
      end_value_r    <= END_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HEADER: header_value_r <= cfg_wdata;
        CFG_END:    end_value_r    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign pos       = first ? POS_HEADER : byte_pos_r;
  assign store_idx = pos - 5'd1;
  assign store_we  = byte_vld && (pos != POS_HEADER) && (pos <= POS_LAST_PAYLOAD);
  assign at_end    = (byte_pos_r == POS_END);

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    hdr_ok_nxt   = hdr_ok_r;
    opt_nxt      = opt_r;
    if (byte_vld) begin
      byte_pos_nxt = pos + 5'd1;
      if (pos == POS_HEADER) begin
        hdr_ok_nxt = (data_byte == header_value_r);
      end else if (pos == POS_OPTION) begin
        opt_nxt = data_byte[OPT_W-1:0];
      end else if (pos == POS_END) begin
        byte_pos_nxt = POS_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= POS_HEADER;
      hdr_ok_r   <= 1'b0;
      opt_r      <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      opt_r      <= opt_nxt;
    end
  end

  // payload store, no reset: every byte is written before a frame can end
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_idx] <= data_byte;
    end
  end

  always_comb begin
    frame.valid = byte_vld && (pos == POS_END);
    frame.good  = hdr_ok_r && (data_byte == end_value_r);
    frame.opt   = opt_r;
    for (int j = 0; j < PAYLOAD_BYTES; j++) begin
      frame.payload[j*8 +: 8] = store_r[j];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rcsd_emit.sv -----
// ----------------------------------------------------------------------------
// rcsd_emit: channel unpacker and output register
// Holds a snapshot of one frame and issues its results one per cycle while out_rdy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsd_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rcsd_pkg::frame_t    frame,
  output logic                     busy,
  output logic                     out_vld,
  input  wire logic                out_rdy,
  output logic [3:0]               channel_index,
  output logic [10:0]              channel_value,
  output logic [3:0]               option_flags,
  output logic                     status,
  output logic                     last
);
  import rcsd_pkg::*;

  logic                 active_r, active_nxt;
  logic                 good_r, good_nxt;
  logic [CH_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [PAYLOAD_W-1:0] buf_r, buf_nxt;
  logic [OPT_W-1:0]     opt_r, opt_nxt;

  logic                 out_vld_r, out_vld_nxt;
  logic [CH_IDX_W-1:0]  idx_r, idx_nxt;
  logic [CH_W-1:0]      val_r, val_nxt;
  logic [OPT_W-1:0]     oflag_r, oflag_nxt;
  logic                 status_r, status_nxt;
  logic                 last_r, last_nxt;
  logic                 load;

  assign load = active_r && (!out_vld_r || out_rdy);
  assign busy = active_r;

  always_comb begin
    active_nxt  = active_r;
    good_nxt    = good_r;
    cnt_nxt     = cnt_r;
    buf_nxt     = buf_r;
    opt_nxt     = opt_r;
    out_vld_nxt = out_vld_r && !out_rdy;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    oflag_nxt   = oflag_r;
    status_nxt  = status_r;
    last_nxt    = last_r;
    if (load) begin
      out_vld_nxt = 1'b1;
      if (good_r) begin
        idx_nxt    = cnt_r;
        val_nxt    = buf_r[CH_W-1:0];
        oflag_nxt  = opt_r;
        status_nxt = 1'b0;
        last_nxt   = (cnt_r == CH_LAST);
        buf_nxt    = buf_r >> CH_W;
        cnt_nxt    = cnt_r + 4'd1;
        active_nxt = (cnt_r != CH_LAST);
      end else begin
        idx_nxt    = '0;
        val_nxt    = '0;
        oflag_nxt  = '0;
        status_nxt = 1'b1;
        last_nxt   = 1'b1;
        active_nxt = 1'b0;
      end
    end else if (!active_r && frame.valid) begin
      active_nxt = 1'b1;
      good_nxt   = frame.good;
      cnt_nxt    = '0;
      buf_nxt    = frame.payload;
      opt_nxt    = frame.opt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    good_r   <= good_nxt;
    cnt_r    <= cnt_nxt;
    buf_r    <= buf_nxt;
    opt_r    <= opt_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    oflag_r  <= oflag_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_vld       = out_vld_r;
  assign channel_index = idx_r;
  assign channel_value = val_r;
  assign option_flags  = oflag_r;
  assign status        = status_r;
  assign last          = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/rc_servo_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rc_servo_frame_decoder: 25-byte, 16-channel, 11-bit servo frame decoder
// Byte stream in, one transaction per decoded channel (or one failure) out.
// ----------------------------------------------------------------------------
// Bytes come one per input transaction, taken each cycle unless stalled; tuser
// marks a byte as frame position 0 and restarts the count, otherwise the
// count runs 0..24 and wraps after the end byte. Position 0 is the header,
// 1..22 the packed channel payload, 23 the option byte, 24 the end byte.
// When the end byte is taken, the header and end byte are checked against
// cfg register 0 (header, reset 0x0F) and 1 (end, reset 0x00). On a match
// the payload is snapshot into the emitter, which issues 16 transactions,
// channel 0..15 in order, one per cycle while out_tready is high; tlast
// marks channel 15. On a mismatch a single transaction with status (tuser)
// set, all data zero and tlast high is issued. The snapshot frees the byte
// store at once, so the next frame streams in while results drain. The only
// input stall: in_tready drops while the count sits at position 24 and the
// emitter is busy, so an end byte, or a tuser byte, that arrives while the
// emitter still holds the previous frame waits.
// Write config only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_servo_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata,
  // byte stream in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tuser,    // [0] first
  // decoded results out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                        // [18:15] option_flags, [23:19] zero
  output logic             out_tuser,   // [0] status
  output logic             out_tlast
);
  import rcsd_pkg::*;

  frame_t      frame;
  logic        at_end;
  logic        emit_busy;
  logic        in_xfer;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic [3:0]  option_flags;

  // Hold off any byte while the count sits at the end position and the previous frame is still draining.
  assign in_tready = !(at_end && emit_busy);
  assign in_xfer   = in_tvalid && in_tready;

  rcsd_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .byte_vld  (in_xfer),
    .data_byte (in_tdata),
    .first     (in_tuser),
    .at_end    (at_end),
    .frame     (frame)
  );

  rcsd_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame         (frame),
    .busy          (emit_busy),
    .out_vld       (out_tvalid),
    .out_rdy       (out_tready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .option_flags  (option_flags),
    .status        (out_tuser),
    .last          (out_tlast)
  );

  assign out_tdata = {5'd0, option_flags, channel_value, channel_index};

endmodule

`default_nettype wire
